[rtl/core/bstk_pkg.sv]
package bstk_pkg;

  // Stack geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W = 32;

  // Fixed field widths of the channels
  localparam int unsigned REQ_W         = 2;
  localparam int unsigned STATUS_W      = 3;
  localparam int unsigned FOUND_INDEX_W = 4;
  localparam int unsigned ENTRY_COUNT_W = 5;

  // Request codes; the unused code is treated as a no-op
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_POP    = 2'd1,
    REQ_SEARCH = 2'd2
  } req_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_OUT
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;     // request transfer this cycle
    logic scan_step;  // advance the search scan
    logic set_found;  // record a hit at the compared index
    logic set_miss;   // record a miss
    logic out_load;   // move the pending result into the output register
  } bstk_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic search_go;  // incoming request is a search on a non-empty stack
    logic match;      // compared entry equals the key
    logic exhausted;  // last entry compared without a match
    logic out_free;   // output register can take a new result
  } bstk_sts_t;

endpackage

[rtl/core/bstk_if.sv]
// Request channel
interface bstk_req_if;
  import bstk_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [REQ_W-1:0]         req_type;
  logic signed [WORD_W-1:0] push_value;
  logic signed [WORD_W-1:0] search_key;

  modport source (output valid, req_type, push_value, search_key, input ready);
  modport sink   (input valid, req_type, push_value, search_key, output ready);
endinterface

// Result channel
interface bstk_rsp_if;
  import bstk_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [FOUND_INDEX_W-1:0] found_index;
  logic [ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, status, found_index, entry_count, input ready);
  modport sink   (input valid, status, found_index, entry_count, output ready);
endinterface

[rtl/core/bounded_stack_with_search_top.sv]
// Sequence: push, pop and the unused request code go from the request transfer to S_OUT and
//   then to the output register; a search on a non-empty stack scans in S_SCAN from the top
//   entry down to a hit or the last entry, then goes to S_OUT; an empty-stack search skips S_SCAN.
// Requests: one at a time; the next is taken back in S_IDLE once the result has been moved
//   to the output register, which waits in S_OUT while the output is stalled.
// Reset (rst_n low, synchronous) empties the stack and drops any pending result.
module bounded_stack_with_search_top
  import bstk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  bstk_req_if.sink   in_ch,
  bstk_rsp_if.source out_ch
);

  bstk_cmd_t cmd;
  bstk_sts_t sts;

  bstk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bstk_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_type        (in_ch.req_type),
    .push_value      (in_ch.push_value),
    .search_key      (in_ch.search_key),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_status      (out_ch.status),
    .out_found_index (out_ch.found_index),
    .out_entry_count (out_ch.entry_count),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

[rtl/core/bstk_ram.sv]
module bstk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/bstk_ctrl.sv]
module bstk_ctrl
  import bstk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bstk_sts_t sts,
  output bstk_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = sts.search_go ? S_SCAN : S_OUT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.match) begin
          cmd.set_found = 1'b1;
          state_nxt     = S_OUT;
        end else if (sts.exhausted) begin
          cmd.set_miss = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/bstk_dp.sv]
module bstk_dp
  import bstk_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  // request payload
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [WORD_W-1:0]  push_value,
  input  logic signed [WORD_W-1:0]  search_key,
  // result channel
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [STATUS_W-1:0]       out_status,
  output logic [FOUND_INDEX_W-1:0]  out_found_index,
  output logic [ENTRY_COUNT_W-1:0]  out_entry_count,
  // control
  input  bstk_cmd_t                 cmd,
  output bstk_sts_t                 sts
);

  // Stack state
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [WORD_W-1:0] key_r, key_nxt;

  // Scan state
  logic [IDX_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              issue_vld_r, issue_vld_nxt;
  logic              cmp_vld_r, cmp_vld_nxt;

  // Pending result and output register
  status_t           res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_index_r, res_index_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [CNT_W-1:0]  out_count_r;

  logic              full, empty, ram_we, ram_re, key_eq;
  logic [WORD_W-1:0] rd_data;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);

  assign ram_we = cmd.accept && (req_type == REQ_PUSH) && !full;
  assign ram_re = cmd.scan_step && issue_vld_r;

  bstk_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .AW    (IDX_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (IDX_W'(count_r)),
    .wr_data (push_value),
    .rd_en   (ram_re),
    .rd_addr (scan_idx_r),
    .rd_data (rd_data)
  );

  assign key_eq = (rd_data == key_r);

  // Status to the controller
  always_comb begin
    sts.search_go = (req_type == REQ_SEARCH) && !empty;
    sts.match     = cmp_vld_r && key_eq;
    sts.exhausted = cmp_vld_r && !key_eq && !issue_vld_r;
    sts.out_free  = !out_valid_r || out_ready;
  end

  // Request handling, scan and result bookkeeping
  always_comb begin
    count_nxt      = count_r;
    key_nxt        = key_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    issue_vld_nxt  = issue_vld_r;
    cmp_vld_nxt    = cmp_vld_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;

    if (cmd.accept) begin
      res_index_nxt = '0;
      unique case (req_type)
        REQ_PUSH: begin
          if (full) begin
            res_status_nxt = ST_FULL;
          end else begin
            count_nxt      = count_r + 1'b1;
            res_status_nxt = ST_DONE;
          end
        end
        REQ_POP: begin
          if (empty) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            count_nxt      = count_r - 1'b1;
            res_status_nxt = ST_DONE;
          end
        end
        REQ_SEARCH: begin
          // scan starts at the top entry
          res_status_nxt = ST_NOT_FOUND;
          key_nxt        = search_key;
          scan_idx_nxt   = IDX_W'(count_r - 1'b1);
          issue_vld_nxt  = !empty;
          cmp_vld_nxt    = 1'b0;
        end
        default: begin
          res_status_nxt = ST_DONE;
        end
      endcase
    end

    // One read issued and one entry compared per cycle
    if (cmd.scan_step) begin
      cmp_vld_nxt = issue_vld_r;
      cmp_idx_nxt = scan_idx_r;
      if (issue_vld_r) begin
        if (scan_idx_r == '0) begin
          issue_vld_nxt = 1'b0;
        end else begin
          scan_idx_nxt = scan_idx_r - 1'b1;
        end
      end
    end

    if (cmd.set_found) begin
      res_status_nxt = ST_FOUND;
      res_index_nxt  = cmp_idx_r;
    end
    if (cmd.set_miss) begin
      res_status_nxt = ST_NOT_FOUND;
      res_index_nxt  = '0;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      issue_vld_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      issue_vld_r <= issue_vld_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    scan_idx_r   <= scan_idx_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = FOUND_INDEX_W'(out_index_r);
  assign out_entry_count = ENTRY_COUNT_W'(out_count_r);

endmodule

[rtl/core/bstk_checker.sv]
module bstk_checker
  import bstk_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [STATUS_W-1:0]      out_status,
  input logic [FOUND_INDEX_W-1:0] out_found_index,
  input logic [ENTRY_COUNT_W-1:0] out_entry_count
);

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_found_index) && $stable(out_entry_count))
    else $error("stalled result changed");

  // Full report only with all entries in use
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_entry_count == ENTRY_COUNT_W'(DEPTH))
    else $error("full status with count below depth");

  // Empty report only with nothing held
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> out_entry_count == '0)
    else $error("empty status with entries held");

  // Index is zero unless a hit
  a_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_FOUND) |-> out_found_index == '0)
    else $error("nonzero index without a hit");

endmodule

bind bounded_stack_with_search_top bstk_checker u_bstk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_index (out_ch.found_index),
  .out_entry_count (out_ch.entry_count)
);
